@@ rtl/icodir_pkg.sv @@
// Shared types and constants for the icon directory parser.
package icodir_pkg;

    localparam int unsigned HDR_LAST_POS = 5;
    localparam int unsigned ENT_LAST_POS = 15;
    localparam int unsigned FIELD_BYTES  = 15;

    localparam logic [15:0] TYPE_ICON   = 16'd1;
    localparam logic [15:0] TYPE_CURSOR = 16'd2;
    localparam logic [8:0]  DIM_ZERO_AS = 9'd256;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_BAD_HEADER = 2'd1;
    localparam logic [1:0] ERR_NO_IMAGES  = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW   = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_ENTRY
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_req;
    } t_in_item;

    typedef struct packed {
        logic [15:0] entry_index;
        logic [8:0]  width;
        logic [8:0]  height;
        logic [15:0] bit_count;
        logic [15:0] cursor_x;
        logic [15:0] cursor_y;
        logic [31:0] image_offset;
        logic [31:0] image_size;
        logic [15:0] best_index;
        logic        last;
        logic [1:0]  error_code;
        logic        is_cursor;
    } t_out_item;

endpackage

@@ rtl/icodir_core.sv @@
// Parse state, field assembly and per-entry descriptor logic.
module icodir_core
    import icodir_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_take,
    input  t_in_item  i_item,
    output logic      o_res_valid,
    output t_out_item o_res
);

    t_phase      r_phase, n_phase;
    logic [3:0]  r_pos, n_pos;
    logic [15:0] r_count, n_count;
    logic [15:0] r_entries, n_entries;
    logic        r_cursor, n_cursor;
    logic [16:0] r_best_area, n_best_area;
    logic [15:0] r_best_bpp, n_best_bpp;
    logic [15:0] r_best_entry, n_best_entry;
    logic [7:0]  r_fb [0:FIELD_BYTES-1];

    t_phase      w_phase;
    logic [3:0]  w_pos;
    logic [15:0] w_count;
    logic [15:0] w_entries;
    logic        w_cursor;
    logic [16:0] w_best_area;
    logic [15:0] w_best_bpp;
    logic [15:0] w_best_entry;
    logic [7:0]  w_cur;

    logic [15:0] w_resv, w_type, w_img_count;
    logic [8:0]  w_width, w_height;
    logic [15:0] w_planes, w_bpp;
    logic [31:0] w_size, w_offset;
    logic [32:0] w_end;
    logic [16:0] w_area;
    logic        w_fin;

    assign w_cur        = i_item.data_byte;
    assign w_phase      = i_item.start_req ? PH_HEADER : r_phase;
    assign w_pos        = i_item.start_req ? 4'd0 : r_pos;
    assign w_count      = i_item.start_req ? 16'd0 : r_count;
    assign w_entries    = i_item.start_req ? 16'd0 : r_entries;
    assign w_cursor     = i_item.start_req ? 1'b0 : r_cursor;
    assign w_best_area  = i_item.start_req ? 17'd0 : r_best_area;
    assign w_best_bpp   = i_item.start_req ? 16'd0 : r_best_bpp;
    assign w_best_entry = i_item.start_req ? 16'd0 : r_best_entry;

    assign w_resv      = {r_fb[1], r_fb[0]};
    assign w_type      = {r_fb[3], r_fb[2]};
    assign w_img_count = {w_cur, r_fb[4]};

    assign w_width  = (r_fb[0] == 8'd0) ? DIM_ZERO_AS : {1'b0, r_fb[0]};
    assign w_height = (r_fb[1] == 8'd0) ? DIM_ZERO_AS : {1'b0, r_fb[1]};
    assign w_planes = {r_fb[5], r_fb[4]};
    assign w_bpp    = {r_fb[7], r_fb[6]};
    assign w_size   = {r_fb[11], r_fb[10], r_fb[9], r_fb[8]};
    assign w_offset = {w_cur, r_fb[14], r_fb[13], r_fb[12]};
    assign w_end    = {1'b0, w_offset} + {1'b0, w_size};
    assign w_area   = {8'd0, w_width} * {8'd0, w_height};
    assign w_fin    = ({1'b0, w_entries} + 17'd1) >= {1'b0, w_count};

    always_comb begin
        n_phase      = w_phase;
        n_pos        = w_pos;
        n_count      = w_count;
        n_entries    = w_entries;
        n_cursor     = w_cursor;
        n_best_area  = w_best_area;
        n_best_bpp   = w_best_bpp;
        n_best_entry = w_best_entry;
        o_res_valid  = 1'b0;
        o_res        = '0;
        case (w_phase)
            PH_HEADER: begin
                if (w_pos < 4'(HDR_LAST_POS)) begin
                    n_pos = w_pos + 4'd1;
                end else begin
                    n_pos = 4'd0;
                    if (w_resv != 16'd0 || (w_type != TYPE_ICON && w_type != TYPE_CURSOR)) begin
                        n_cursor          = 1'b0;
                        n_phase           = PH_IDLE;
                        o_res_valid       = 1'b1;
                        o_res.entry_index = w_entries;
                        o_res.last        = 1'b1;
                        o_res.error_code  = ERR_BAD_HEADER;
                    end else begin
                        n_cursor = (w_type == TYPE_CURSOR);
                        n_count  = w_img_count;
                        if (w_img_count == 16'd0) begin
                            n_phase           = PH_IDLE;
                            o_res_valid       = 1'b1;
                            o_res.entry_index = w_entries;
                            o_res.last        = 1'b1;
                            o_res.error_code  = ERR_NO_IMAGES;
                            o_res.is_cursor   = (w_type == TYPE_CURSOR);
                        end else begin
                            n_phase = PH_ENTRY;
                        end
                    end
                end
            end
            PH_ENTRY: begin
                if (w_pos < 4'(ENT_LAST_POS)) begin
                    n_pos = w_pos + 4'd1;
                end else begin
                    n_pos       = 4'd0;
                    o_res_valid = 1'b1;
                    if (w_end[32]) begin
                        n_phase           = PH_IDLE;
                        o_res.entry_index = w_entries;
                        o_res.last        = 1'b1;
                        o_res.error_code  = ERR_OVERFLOW;
                        o_res.is_cursor   = w_cursor;
                    end else begin
                        if (w_area >= w_best_area && w_bpp > w_best_bpp) begin
                            n_best_area  = w_area;
                            n_best_bpp   = w_bpp;
                            n_best_entry = w_entries;
                        end
                        o_res.entry_index  = w_entries;
                        o_res.width        = w_width;
                        o_res.height       = w_height;
                        o_res.bit_count    = w_bpp;
                        o_res.cursor_x     = w_cursor ? w_planes : 16'd0;
                        o_res.cursor_y     = w_cursor ? w_bpp : 16'd0;
                        o_res.image_offset = w_offset;
                        o_res.image_size   = w_size;
                        o_res.best_index   = n_best_entry;
                        o_res.last         = w_fin;
                        o_res.error_code   = ERR_NONE;
                        o_res.is_cursor    = w_cursor;
                        n_entries          = w_entries + 16'd1;
                        if (w_fin) begin
                            n_phase = PH_IDLE;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_pos        <= 4'd0;
            r_count      <= 16'd0;
            r_entries    <= 16'd0;
            r_cursor     <= 1'b0;
            r_best_area  <= 17'd0;
            r_best_bpp   <= 16'd0;
            r_best_entry <= 16'd0;
        end else if (i_take) begin
            r_phase      <= n_phase;
            r_pos        <= n_pos;
            r_count      <= n_count;
            r_entries    <= n_entries;
            r_cursor     <= n_cursor;
            r_best_area  <= n_best_area;
            r_best_bpp   <= n_best_bpp;
            r_best_entry <= n_best_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && (w_phase == PH_HEADER || w_phase == PH_ENTRY)
                && w_pos < 4'(FIELD_BYTES)) begin
            r_fb[w_pos] <= w_cur;
        end
    end

endmodule

@@ rtl/icon_directory_parser_unit.sv @@
// Channel   Direction  Handshake                   Payload
// in        input      i_in_valid / o_in_stall     i_in_item  (t_in_item)
// out       output     o_out_valid / i_out_stall   o_out_item (t_out_item)
// One byte is taken per cycle while not stalled; the edge that takes the last byte
// of a header or entry also loads its descriptor or error into the result register.
// Bytes pass an input register, then the parse logic, then the result register.
// Reset clears the parse state to idle; a start flag restarts the parse at any byte.
// A held result stalls the input register only when that result is itself stalled.
module icon_directory_parser_unit
    import icodir_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    logic      w_adv;
    logic      w_take;
    logic      w_res_valid;
    t_out_item w_res;

    assign w_adv      = !r_out_valid || !i_out_stall;
    assign w_take     = r_in_valid && w_adv;
    assign o_in_stall = r_in_valid && !w_adv;

    icodir_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (w_take),
        .i_item      (r_in),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_take && w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTH
    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.error_code != ERR_NONE |-> o_out_item.last)
        else $error("error transaction without last");

    a_dims_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.error_code == ERR_NONE
        |-> o_out_item.width != 9'd0 && o_out_item.height != 9'd0)
        else $error("descriptor with zero dimension");

    a_icon_no_hotspot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.is_cursor
        |-> o_out_item.cursor_x == 16'd0 && o_out_item.cursor_y == 16'd0)
        else $error("icon transaction carries a hotspot");

    a_best_not_ahead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.error_code == ERR_NONE
        |-> o_out_item.best_index <= o_out_item.entry_index)
        else $error("best index beyond current entry");
`endif

endmodule

@@ tb/icon_directory_parser_unit_tb.sv @@
// Self-checking testbench for the icon directory parser: byte stream in, entry descriptors out.
module icon_directory_parser_unit_tb;
    import icodir_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_item = '0;
    logic      out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    icon_directory_parser_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    t_in_item  bytes_pending[$];
    t_out_item descriptors_due[$];

    int unsigned stim_bytes;
    int unsigned bytes_taken;
    int unsigned entries_checked;
    int unsigned errors_checked;
    int unsigned mismatches;
    int unsigned cycle_no;
    int unsigned in_gap;
    int unsigned stall_left;

    // Shadow of the parser state.
    t_phase      parse_phase = PH_IDLE;
    logic [3:0]  parse_pos = '0;
    logic [7:0]  dir_bytes[16];
    logic [15:0] file_images = '0;
    logic [15:0] entries_seen = '0;
    logic        cursor_file = 1'b0;
    logic [16:0] best_area = '0;
    logic [15:0] best_bits = '0;
    logic [15:0] best_entry = '0;

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        mismatches++;
        if (mismatches <= 40)
            $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    endtask

    task automatic queue_error(input logic [1:0] code);
        t_out_item d;
        d = '0;
        d.entry_index = entries_seen;
        d.last = 1'b1;
        d.error_code = code;
        d.is_cursor = cursor_file;
        descriptors_due.push_back(d);
        parse_phase = PH_IDLE;
    endtask

    task automatic parse_byte(input t_in_item it);
        t_out_item   d;
        logic [15:0] resv, ftype, planes, bpp;
        logic [8:0]  w, h;
        logic [31:0] size, offset;
        logic [16:0] area;
        logic        fin;
        if (it.start_req) begin
            parse_phase = PH_HEADER;
            parse_pos = '0;
            file_images = '0;
            entries_seen = '0;
            cursor_file = 1'b0;
            best_area = '0;
            best_bits = '0;
            best_entry = '0;
        end
        if (parse_phase == PH_IDLE)
            return;
        dir_bytes[parse_pos] = it.data_byte;
        if (parse_phase == PH_HEADER) begin
            if (parse_pos < HDR_LAST_POS) begin
                parse_pos++;
                return;
            end
            parse_pos = '0;
            resv = {dir_bytes[1], dir_bytes[0]};
            ftype = {dir_bytes[3], dir_bytes[2]};
            if (resv != 16'd0 || (ftype != TYPE_ICON && ftype != TYPE_CURSOR)) begin
                cursor_file = 1'b0;
                queue_error(ERR_BAD_HEADER);
                return;
            end
            cursor_file = (ftype == TYPE_CURSOR);
            file_images = {dir_bytes[5], dir_bytes[4]};
            if (file_images == 16'd0) begin
                queue_error(ERR_NO_IMAGES);
                return;
            end
            parse_phase = PH_ENTRY;
            return;
        end
        if (parse_pos < ENT_LAST_POS) begin
            parse_pos++;
            return;
        end
        parse_pos = '0;
        w = (dir_bytes[0] == 8'd0) ? DIM_ZERO_AS : {1'b0, dir_bytes[0]};
        h = (dir_bytes[1] == 8'd0) ? DIM_ZERO_AS : {1'b0, dir_bytes[1]};
        planes = {dir_bytes[5], dir_bytes[4]};
        bpp = {dir_bytes[7], dir_bytes[6]};
        size = {dir_bytes[11], dir_bytes[10], dir_bytes[9], dir_bytes[8]};
        offset = {dir_bytes[15], dir_bytes[14], dir_bytes[13], dir_bytes[12]};
        if ({1'b0, offset} + {1'b0, size} > 33'h0_FFFF_FFFF) begin
            queue_error(ERR_OVERFLOW);
            return;
        end
        area = {8'd0, w} * {8'd0, h};
        if (area >= best_area && bpp > best_bits) begin
            best_area = area;
            best_bits = bpp;
            best_entry = entries_seen;
        end
        fin = ({1'b0, entries_seen} + 17'd1) >= {1'b0, file_images};
        d.entry_index = entries_seen;
        d.width = w;
        d.height = h;
        d.bit_count = bpp;
        d.cursor_x = cursor_file ? planes : 16'd0;
        d.cursor_y = cursor_file ? bpp : 16'd0;
        d.image_offset = offset;
        d.image_size = size;
        d.best_index = best_entry;
        d.last = fin;
        d.error_code = ERR_NONE;
        d.is_cursor = cursor_file;
        descriptors_due.push_back(d);
        entries_seen++;
        if (fin)
            parse_phase = PH_IDLE;
    endtask

    task automatic check_descriptor(input t_out_item got, input t_out_item want);
        if (got.entry_index !== want.entry_index)
            report_mismatch("entry_index", got.entry_index, want.entry_index);
        if (got.width !== want.width)
            report_mismatch("width", got.width, want.width);
        if (got.height !== want.height)
            report_mismatch("height", got.height, want.height);
        if (got.bit_count !== want.bit_count)
            report_mismatch("bit_count", got.bit_count, want.bit_count);
        if (got.cursor_x !== want.cursor_x)
            report_mismatch("cursor_x", got.cursor_x, want.cursor_x);
        if (got.cursor_y !== want.cursor_y)
            report_mismatch("cursor_y", got.cursor_y, want.cursor_y);
        if (got.image_offset !== want.image_offset)
            report_mismatch("image_offset", got.image_offset, want.image_offset);
        if (got.image_size !== want.image_size)
            report_mismatch("image_size", got.image_size, want.image_size);
        if (got.best_index !== want.best_index)
            report_mismatch("best_index", got.best_index, want.best_index);
        if (got.last !== want.last)
            report_mismatch("last", got.last, want.last);
        if (got.error_code !== want.error_code)
            report_mismatch("error_code", got.error_code, want.error_code);
        if (got.is_cursor !== want.is_cursor)
            report_mismatch("is_cursor", got.is_cursor, want.is_cursor);
    endtask

    function automatic bit idling_allowed();
        return cycle_no[8:7] != 2'b00 && bytes_pending.size() > 200;
    endfunction

    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_item <= '0;
        end else begin
            if (in_valid && !o_in_stall) begin
                parse_byte(in_item);
                bytes_taken++;
            end
            if (!in_valid || !o_in_stall) begin
                if (in_gap != 0) begin
                    in_valid <= 1'b0;
                    in_gap--;
                end else if (bytes_pending.size() != 0) begin
                    in_valid <= 1'b1;
                    in_item <= bytes_pending.pop_front();
                    if (idling_allowed() && $urandom_range(0, 7) == 0)
                        in_gap = $urandom_range(1, 6);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (descriptors_due.size() == 0) begin
                    report_mismatch("result with nothing expected, entry_index",
                                    o_out_item.entry_index, 0);
                end else begin
                    if (o_out_item.error_code != ERR_NONE)
                        errors_checked++;
                    else
                        entries_checked++;
                    check_descriptor(o_out_item, descriptors_due.pop_front());
                end
            end
            if (stall_left == 0 && idling_allowed() && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 6);
            out_stall <= (stall_left != 0);
            if (stall_left != 0)
                stall_left--;
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic st);
        t_in_item it;
        it.data_byte = b;
        it.start_req = st;
        bytes_pending.push_back(it);
        stim_bytes++;
    endtask

    task automatic push_header(input logic [15:0] resv, input logic [15:0] ftype,
                               input logic [15:0] count, input int nbytes);
        logic [47:0] hdr;
        hdr = {count, ftype, resv};
        for (int i = 0; i < nbytes; i++)
            push_byte(hdr[8*i +: 8], i == 0);
    endtask

    task automatic push_entry(input logic [7:0] w, input logic [7:0] h,
                              input logic [15:0] planes, input logic [15:0] bpp,
                              input logic [31:0] size, input logic [31:0] offset,
                              input int nbytes);
        logic [127:0] ent;
        ent = {offset, size, bpp, planes, 8'($urandom), 8'($urandom), h, w};
        for (int i = 0; i < nbytes; i++)
            push_byte(ent[8*i +: 8], 1'b0);
    endtask

    task automatic push_random_entry(input bit overflow, input int nbytes);
        logic [7:0]  w, h;
        logic [15:0] planes, bpp;
        logic [31:0] size, offset;
        w = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
        h = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
        planes = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 2)) : 16'($urandom);
        case ($urandom_range(0, 3))
            0: bpp = 16'($urandom);
            1: bpp = 16'($urandom_range(0, 2));
            default: bpp = 16'(1 << $urandom_range(0, 5));
        endcase
        offset = $urandom;
        if (overflow) begin
            offset[31] = 1'b1;
            size = (32'd0 - offset) + 32'($urandom_range(0, 15));
        end else if ($urandom_range(0, 7) == 0) begin
            size = ~offset;
        end else begin
            size = 32'({32'd0, $urandom} % ({32'd0, ~offset} + 64'd1));
        end
        push_entry(w, h, planes, bpp, size, offset, nbytes);
    endtask

    task automatic push_random_file(output bit ends_idle);
        int          kind, count, full;
        logic [15:0] resv, ftype;
        kind = $urandom_range(0, 99);
        ends_idle = 1'b1;
        if (kind < 7) begin
            resv = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'd0;
            ftype = 16'($urandom);
            if (resv == 16'd0 && (ftype == TYPE_ICON || ftype == TYPE_CURSOR))
                ftype = 16'($urandom_range(0, 1)) * 16'd3;
            push_header(resv, ftype, 16'($urandom), 6);
        end else if (kind < 11) begin
            push_header(16'd0, $urandom_range(0, 1) ? TYPE_CURSOR : TYPE_ICON, 16'd0, 6);
        end else if (kind < 19) begin
            ends_idle = 1'b0;
            if ($urandom_range(0, 3) == 0) begin
                push_header(16'd0, TYPE_CURSOR, 16'($urandom), $urandom_range(1, 5));
            end else begin
                push_header(16'd0, $urandom_range(0, 1) ? TYPE_CURSOR : TYPE_ICON,
                            ($urandom_range(0, 1) ? 16'($urandom) | 16'h0008
                                                  : 16'($urandom_range(4, 8))), 6);
                full = $urandom_range(0, 3);
                for (int i = 0; i < full; i++)
                    push_random_entry(1'b0, 16);
                push_random_entry(1'b0, $urandom_range(0, 15));
            end
        end else begin
            count = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
            push_header(16'd0, $urandom_range(0, 1) ? TYPE_CURSOR : TYPE_ICON,
                        16'(count), 6);
            for (int i = 0; i < count; i++) begin
                if ($urandom_range(0, 24) == 0) begin
                    push_random_entry(1'b1, 16);
                    break;
                end
                push_random_entry(1'b0, 16);
            end
        end
    endtask

    initial begin
        bit parser_idle;
        int n;
        t_in_item stray;

        // Bytes before any start are ignored.
        for (int i = 0; i < 2; i++) begin
            stray.data_byte = 8'($urandom);
            stray.start_req = 1'b0;
            bytes_pending.push_back(stray);
        end
        // A header cut short by a restart, then an unknown file type, a nonzero reserved word and no images.
        push_header(16'd0, TYPE_ICON, 16'd1, 3);
        push_header(16'd0, 16'h0203, 16'd1, 6);
        push_header(16'hFFFF, TYPE_ICON, 16'hFFFF, 6);
        push_header(16'd0, TYPE_ICON, 16'd0, 6);
        // Cursor with zero dimensions, all-ones words and offset plus size at the limit.
        push_header(16'd0, TYPE_CURSOR, 16'd1, 6);
        push_entry(8'd0, 8'd0, 16'hFFFF, 16'hFFFF, 32'd1, 32'hFFFF_FFFE, 16);

        parser_idle = 1'b1;
        while (stim_bytes < 1300) begin
            if (parser_idle && $urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) begin
                    stray.data_byte = 8'($urandom);
                    stray.start_req = 1'b0;
                    bytes_pending.push_back(stray);
                end
            end
            push_random_file(parser_idle);
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (bytes_pending.size() == 0 && !in_valid);
        for (n = 0; n < 5000 && descriptors_due.size() != 0; n++)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (descriptors_due.size() != 0)
            report_mismatch("results never delivered, count", descriptors_due.size(), 0);

        $display("Run covered %0d bytes taken, %0d descriptors and %0d error results checked.",
                 bytes_taken, entries_checked, errors_checked);
        if (mismatches == 0) begin
            $display("icon_directory_parser_unit_tb passed");
        end else begin
            $display("%0d mismatches found.", mismatches);
            $display("icon_directory_parser_unit_tb failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d results outstanding.", descriptors_due.size());
        $display("icon_directory_parser_unit_tb failed");
        $finish;
    end

endmodule
